// ===== rtl/dual_rgb_led_pwm_controller_defines.svh =====
// assertion macros for the dual rgb led pwm controller checker
// no dependencies; included by the checker file
`ifndef DUAL_RGB_LED_PWM_CONTROLLER_DEFINES_SVH
`define DUAL_RGB_LED_PWM_CONTROLLER_DEFINES_SVH

// same-cycle implication, off during reset
`define DRLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define DRLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// state right after a reset cycle
`define DRLP_ASSERT_AFTER_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/drlp_pkg.sv =====
// shared types and constants of the dual rgb led pwm controller
// no dependencies; used by every rtl module and the checker
package drlp_pkg;

    // pwm resolution and near-white threshold
    localparam int DUTY_BITS   = 6;
    localparam int WHITE_LIMIT = 50;
    localparam int FULL_DUTY   = (1 << DUTY_BITS) - 1;

    localparam int COLOR_W  = 8;
    localparam int NUM_CH   = 6;
    localparam int LED_CH   = 3;
    localparam int PAT_W    = 7;
    localparam int TICK_W   = 16;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // divider for value * FULL_DUTY / scale
    localparam int DIVW      = COLOR_W + DUTY_BITS;
    localparam int DIV_CNT_W = $clog2(DIVW);

    // port widths
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // output word bit positions
    localparam int OUT_TICK_LSB  = NUM_CH;
    localparam int OUT_TICK_MSB  = NUM_CH + TICK_W - 1;
    localparam int OUT_START_BIT = NUM_CH + TICK_W;

    typedef logic [DUTY_BITS-1:0] t_duty;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_COLOUR = 2'd1,
        OP_FULL   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALING = 1'b0,
        CFG_INVERT  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic scaling;
        logic invert;
    } t_cfg;

    // decoded command as it sits in the queue
    typedef struct packed {
        t_opcode             op;
        logic                led;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic                allow_white;
        logic [NUM_CH-1:0]   full_pins;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_out;

    typedef struct packed {
        logic               start;
        logic [DIVW-1:0]    dividend;
        logic [COLOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [DIVW-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/drlp_front.sv =====
// front end: accepts input words, decodes them into commands, two-entry queue
// depends on drlp_pkg
module drlp_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // red[7:0], green[15:8], blue[23:16], allow_white[24], full_pattern[31:25]
    input  logic [drlp_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // opcode[1:0], led_select[2]
    input  logic [drlp_pkg::IN_USER_W-1:0]   i_s_tuser,
    input  logic                             i_pop,
    output drlp_pkg::t_q_out                 o_q
);

    localparam int QD = 2;

    drlp_pkg::t_cmd r_q [QD];
    drlp_pkg::t_cmd n_q [QD];
    logic [1:0]     r_cnt, n_cnt;
    logic           r_wp, n_wp;
    logic           r_rp, n_rp;

    drlp_pkg::t_cmd                w_cmd;
    logic [drlp_pkg::PAT_W-1:0]    w_pat;
    logic                          w_push;

    // decode the word into a command
    always_comb begin
        w_pat             = i_s_tdata[31:25];
        w_cmd.op          = drlp_pkg::t_opcode'(i_s_tuser[1:0]);
        w_cmd.led         = i_s_tuser[2];
        w_cmd.red         = i_s_tdata[7:0];
        w_cmd.green       = i_s_tdata[15:8];
        w_cmd.blue        = i_s_tdata[23:16];
        w_cmd.allow_white = i_s_tdata[24];
        // pattern bit 3 is a gap between the two leds
        w_cmd.full_pins   = {w_pat[6:4], w_pat[2:0]};
    end

    assign o_s_tready = (r_cnt != 2'(QD));
    assign w_push     = i_s_tvalid && o_s_tready;

    // queue pointers and fill count
    always_comb begin
        n_q   = r_q;
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_q[r_wp] = w_cmd;
            n_wp      = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        unique case ({w_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_wp  <= n_wp;
            r_rp  <= n_rp;
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

// ===== rtl/drlp_div.sv =====
// shift-subtract divider, one quotient bit per cycle
// depends on drlp_pkg
module drlp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  drlp_pkg::t_div_req  i_req,
    output drlp_pkg::t_div_rsp  o_rsp
);

    logic [drlp_pkg::DIVW-1:0]      r_quo, n_quo;
    logic [drlp_pkg::COLOR_W-1:0]   r_rem, n_rem;
    logic [drlp_pkg::COLOR_W-1:0]   r_dsr, n_dsr;
    logic [drlp_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;

    logic [drlp_pkg::COLOR_W:0]     w_trial;
    logic [drlp_pkg::COLOR_W:0]     w_diff;
    logic                           w_ge;

    // one restoring step
    always_comb begin
        w_trial = {r_rem, r_quo[drlp_pkg::DIVW-1]};
        w_ge    = (w_trial >= {1'b0, r_dsr});
        w_diff  = w_trial - {1'b0, r_dsr};
    end

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dsr  = i_req.divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[drlp_pkg::COLOR_W-1:0] : w_trial[drlp_pkg::COLOR_W-1:0];
            n_quo = {r_quo[drlp_pkg::DIVW-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == drlp_pkg::DIV_CNT_W'(drlp_pkg::DIVW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/drlp_back.sv =====
// back end: pwm state, colour conversion sequencer, output register
// depends on drlp_pkg and drlp_div
module drlp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  drlp_pkg::t_cfg                    i_cfg,
    input  drlp_pkg::t_q_out                  i_q,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // led_pins[5:0], tick_count[21:6], period_start[22], zero[23]
    output logic [drlp_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    typedef enum logic [4:0] {
        BK_IDLE  = 5'b00001,
        BK_LOAD  = 5'b00010,
        BK_WAIT  = 5'b00100,
        BK_CHECK = 5'b01000,
        BK_DONE  = 5'b10000
    } t_back_state;

    localparam logic [drlp_pkg::COLOR_W-1:0] WHITE_LVL = drlp_pkg::COLOR_W'(drlp_pkg::WHITE_LIMIT);

    t_back_state r_state, n_state;

    // pwm and period state
    logic                              r_full_mode, n_full_mode;
    drlp_pkg::t_duty                   r_phase, n_phase;
    drlp_pkg::t_duty                   r_pending [drlp_pkg::NUM_CH];
    drlp_pkg::t_duty                   n_pending [drlp_pkg::NUM_CH];
    drlp_pkg::t_duty                   r_active  [drlp_pkg::NUM_CH];
    drlp_pkg::t_duty                   n_active  [drlp_pkg::NUM_CH];
    logic [drlp_pkg::TICK_W-1:0]       r_ticks, n_ticks;
    logic [drlp_pkg::COLOR_W-1:0]      r_var, n_var;
    logic [drlp_pkg::NUM_CH-1:0]       r_pins, n_pins;

    // conversion working registers
    logic                              r_led, n_led;
    logic                              r_allow_white, n_allow_white;
    logic                              r_second, n_second;
    logic [drlp_pkg::COLOR_W-1:0]      r_col [drlp_pkg::LED_CH];
    logic [drlp_pkg::COLOR_W-1:0]      n_col [drlp_pkg::LED_CH];
    logic [drlp_pkg::COLOR_W-1:0]      r_scale, n_scale;
    logic [1:0]                        r_comp, n_comp;
    drlp_pkg::t_duty                   r_duty [drlp_pkg::LED_CH];
    drlp_pkg::t_duty                   n_duty [drlp_pkg::LED_CH];

    // output register
    logic                              r_out_valid, n_out_valid;
    logic [drlp_pkg::NUM_CH-1:0]       r_out_pins, n_out_pins;
    logic [drlp_pkg::TICK_W-1:0]       r_out_ticks, n_out_ticks;
    logic                              r_out_start, n_out_start;

    logic                              w_out_free;
    logic                              w_start;
    logic                              w_emit;
    logic                              w_white;
    logic [drlp_pkg::NUM_CH-1:0]       w_mask;
    logic [drlp_pkg::COLOR_W-1:0]      w_cur_col;
    drlp_pkg::t_div_req                w_div_req;
    drlp_pkg::t_div_rsp                w_div_rsp;

    // divisor: full duty, or the brightest component when scaling
    function automatic logic [drlp_pkg::COLOR_W-1:0] f_scale(
        input logic                         scaling,
        input logic [drlp_pkg::COLOR_W-1:0] a,
        input logic [drlp_pkg::COLOR_W-1:0] b,
        input logic [drlp_pkg::COLOR_W-1:0] c
    );
        logic [drlp_pkg::COLOR_W-1:0] m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        return scaling ? m : drlp_pkg::COLOR_W'(drlp_pkg::FULL_DUTY);
    endfunction

    drlp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // pwm compare of the current phase against each active duty
    always_comb begin
        for (int i = 0; i < drlp_pkg::NUM_CH; i++) begin
            w_mask[i] = (r_phase < r_active[i]);
        end
    end

    // value * full_duty as a shift and subtract
    assign w_cur_col          = r_col[r_comp];
    assign w_div_req.dividend = {w_cur_col, {drlp_pkg::DUTY_BITS{1'b0}}}
                                - drlp_pkg::DIVW'(w_cur_col);
    assign w_div_req.divisor  = r_scale;
    assign w_div_req.start    = (r_state == BK_LOAD);

    // near-white test on the three fresh duties
    assign w_white = !r_allow_white && !r_second
                     && (drlp_pkg::COLOR_W'(r_duty[0]) > WHITE_LVL)
                     && (drlp_pkg::COLOR_W'(r_duty[1]) > WHITE_LVL)
                     && (drlp_pkg::COLOR_W'(r_duty[2]) > WHITE_LVL);

    assign w_out_free = !r_out_valid || i_m_tready;

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_full_mode   = r_full_mode;
        n_phase       = r_phase;
        n_pending     = r_pending;
        n_active      = r_active;
        n_ticks       = r_ticks;
        n_var         = r_var;
        n_pins        = r_pins;
        n_led         = r_led;
        n_allow_white = r_allow_white;
        n_second      = r_second;
        n_col         = r_col;
        n_scale       = r_scale;
        n_comp        = r_comp;
        n_duty        = r_duty;
        n_out_valid   = r_out_valid;
        n_out_pins    = r_out_pins;
        n_out_ticks   = r_out_ticks;
        n_out_start   = r_out_start;
        o_pop         = 1'b0;
        w_start       = 1'b0;
        w_emit        = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            BK_IDLE: begin
                if (i_q.valid && w_out_free) begin
                    o_pop = 1'b1;
                    unique case (i_q.cmd.op)
                        drlp_pkg::OP_TICK: begin
                            w_emit = 1'b1;
                            if (!r_full_mode) begin
                                n_pins  = w_mask;
                                n_phase = r_phase - 1'b1;
                                // period wrap: load pending duties
                                if (n_phase == '0) begin
                                    n_active = r_pending;
                                    w_start  = 1'b1;
                                    if (r_ticks != drlp_pkg::TICK_MAX) begin
                                        n_ticks = r_ticks + 1'b1;
                                    end
                                end
                            end
                        end
                        drlp_pkg::OP_COLOUR: begin
                            n_full_mode   = 1'b0;
                            n_led         = i_q.cmd.led;
                            n_allow_white = i_q.cmd.allow_white;
                            n_col[0]      = i_q.cmd.red;
                            n_col[1]      = i_q.cmd.green;
                            n_col[2]      = i_q.cmd.blue;
                            n_scale       = f_scale(i_cfg.scaling, i_q.cmd.red,
                                                    i_q.cmd.green, i_q.cmd.blue);
                            n_second      = 1'b0;
                            n_comp        = 2'd0;
                            n_state       = BK_LOAD;
                        end
                        drlp_pkg::OP_FULL: begin
                            w_emit      = 1'b1;
                            n_full_mode = 1'b1;
                            n_pins      = i_q.cmd.full_pins;
                        end
                        drlp_pkg::OP_NOP: begin
                            w_emit = 1'b1;
                        end
                    endcase
                end
            end
            BK_LOAD: begin
                n_state = BK_WAIT;
            end
            BK_WAIT: begin
                if (w_div_rsp.done) begin
                    // zero scale gives zero duty
                    n_duty[r_comp] = (r_scale == '0) ? '0
                                     : w_div_rsp.quotient[drlp_pkg::DUTY_BITS-1:0];
                    if (r_comp == 2'd2) begin
                        n_state = BK_CHECK;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = BK_LOAD;
                    end
                end
            end
            BK_CHECK: begin
                if (w_white) begin
                    // substitute colour, converted once more
                    n_var    = r_var + 1'b1;
                    n_col[0] = drlp_pkg::COLOR_W'(n_var[drlp_pkg::DUTY_BITS-1:0]);
                    n_col[1] = drlp_pkg::COLOR_W'(r_ticks[drlp_pkg::DUTY_BITS-1:0]);
                    n_col[2] = '0;
                    n_scale  = f_scale(i_cfg.scaling, n_col[0], n_col[1], n_col[2]);
                    n_second = 1'b1;
                    n_comp   = 2'd0;
                    n_state  = BK_LOAD;
                end else begin
                    for (int k = 0; k < drlp_pkg::LED_CH; k++) begin
                        if (r_led) begin
                            n_pending[drlp_pkg::LED_CH + k] = r_duty[k];
                        end else begin
                            n_pending[k] = r_duty[k];
                        end
                    end
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        // result word into the output register
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_pins  = n_pins ^ {drlp_pkg::NUM_CH{i_cfg.invert}};
            n_out_ticks = n_ticks;
            n_out_start = w_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_full_mode <= 1'b0;
            r_phase     <= '0;
            r_ticks     <= '0;
            r_var       <= '0;
            r_pins      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < drlp_pkg::NUM_CH; i++) begin
                r_pending[i] <= '0;
                r_active[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_full_mode <= n_full_mode;
            r_phase     <= n_phase;
            r_ticks     <= n_ticks;
            r_var       <= n_var;
            r_pins      <= n_pins;
            r_out_valid <= n_out_valid;
            r_pending   <= n_pending;
            r_active    <= n_active;
        end
    end

    // working and output payload
    always_ff @(posedge i_clk) begin
        r_led         <= n_led;
        r_allow_white <= n_allow_white;
        r_second      <= n_second;
        r_col         <= n_col;
        r_scale       <= n_scale;
        r_comp        <= n_comp;
        r_duty        <= n_duty;
        r_out_pins    <= n_out_pins;
        r_out_ticks   <= n_out_ticks;
        r_out_start   <= n_out_start;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_start, r_out_ticks, r_out_pins};

endmodule

// ===== rtl/dual_rgb_led_pwm_controller.sv =====
// Tick, set-full and no-op words: the result is written to the output register as the word leaves the queue.
// Set-colour words: the three components are converted one after another by the one-bit-per-cycle
//   divider that they share, into 6-bit duties; the conversion runs a second time when the
//   near-white substitute is converted.
// A two-word queue lets new words be taken while the back end works or the output stalls.
// Reset (synchronous, active low) clears duties, phase, counters, pins and config to zero.
module dual_rgb_led_pwm_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // red[7:0], green[15:8], blue[23:16], allow_white[24], full_pattern[31:25]
    input  logic [drlp_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // opcode[1:0], led_select[2]
    input  logic [drlp_pkg::IN_USER_W-1:0]    i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // led_pins[5:0], tick_count[21:6], period_start[22], zero[23]
    output logic [drlp_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  logic                              i_cfg_we,
    input  logic [drlp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [drlp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    drlp_pkg::t_cfg   r_cfg, n_cfg;
    drlp_pkg::t_q_out w_q;
    logic             w_pop;

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (drlp_pkg::t_cfg_idx'(i_cfg_idx))
                drlp_pkg::CFG_SCALING: n_cfg.scaling = i_cfg_data[0];
                drlp_pkg::CFG_INVERT:  n_cfg.invert  = i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    drlp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_pop      (w_pop),
        .o_q        (w_q)
    );

    drlp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q        (w_q),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== rtl/drlp_checker.sv =====
// port-level checks of the dual rgb led pwm controller, bound to the top level
// depends on drlp_pkg and dual_rgb_led_pwm_controller_defines.svh
`include "dual_rgb_led_pwm_controller_defines.svh"

module drlp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [drlp_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    logic [drlp_pkg::TICK_W-1:0] r_last_ticks;
    logic [drlp_pkg::TICK_W-1:0] w_ticks;
    logic [drlp_pkg::TICK_W-1:0] w_next;
    logic                        w_acc;
    logic                        w_period;

    assign w_acc    = o_m_tvalid && i_m_tready;
    assign w_ticks  = o_m_tdata[drlp_pkg::OUT_TICK_MSB:drlp_pkg::OUT_TICK_LSB];
    assign w_period = o_m_tdata[drlp_pkg::OUT_START_BIT];
    assign w_next   = r_last_ticks + 1'b1;

    // tick count of the last delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ticks <= '0;
        end else if (w_acc) begin
            r_last_ticks <= w_ticks;
        end
    end

    `DRLP_ASSERT_AFTER_RESET(a_reset_empty, !o_m_tvalid && o_s_tready, "not empty after reset")
    `DRLP_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled word changed")
    `DRLP_ASSERT_NOW(a_ticks_mono, w_acc, w_ticks >= r_last_ticks, "tick count went down")
    `DRLP_ASSERT_NOW(a_period_step, w_acc && w_period, (w_ticks == w_next) || ((w_ticks == drlp_pkg::TICK_MAX) && (r_last_ticks == drlp_pkg::TICK_MAX)), "period start without count step")

endmodule

bind dual_rgb_led_pwm_controller drlp_checker u_drlp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/led_pwm_checker.sv =====
`timescale 1ns / 1ps
// checker for the dual rgb led pwm controller: mirrors the controller state from the
// accepted words and compares every output word field by field; depends on drlp_pkg
module led_pwm_checker
    import drlp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // red[7:0], green[15:8], blue[23:16], allow_white[24], full_pattern[31:25]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // opcode[1:0], led_select[2]
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // led_pins[5:0], tick_count[21:6], period_start[22], zero[23]
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    typedef struct {
        logic [NUM_CH-1:0] pins;
        logic [TICK_W-1:0] ticks;
        logic              start;
    } t_led_status;

    // mirrored controller state
    logic               scale_mode;
    logic               invert_mode;
    logic               full_mode;
    t_duty              pwm_phase;
    t_duty              pending_duty [NUM_CH];
    t_duty              active_duty [NUM_CH];
    logic [TICK_W-1:0]  period_ticks;
    logic [7:0]         variation_count;
    logic [NUM_CH-1:0]  pin_state;

    // output words still owed by the controller, oldest first
    t_led_status status_due [$];

    // value * full duty / scale, kept to the duty width
    function automatic t_duty duty_of(input logic [COLOR_W-1:0] value,
                                      input logic [COLOR_W-1:0] scale);
        int unsigned quotient;
        if (scale == '0)
            return '0;
        quotient = (int'(value) * FULL_DUTY) / int'(scale);
        return t_duty'(quotient);
    endfunction

    // convert one colour into the pending duties of one led
    task automatic load_pending(input int base, input logic [COLOR_W-1:0] r,
                                input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] scale;
        scale = COLOR_W'(FULL_DUTY);
        if (scale_mode) begin
            scale = r;
            if (g > scale) scale = g;
            if (b > scale) scale = b;
        end
        pending_duty[base]     = duty_of(r, scale);
        pending_duty[base + 1] = duty_of(g, scale);
        pending_duty[base + 2] = duty_of(b, scale);
    endtask

    // advance the mirrored state by one accepted word
    task automatic apply_word(input logic [IN_DATA_W-1:0] data,
                              input logic [IN_USER_W-1:0] user, output t_led_status status);
        t_opcode            op;
        int                 base;
        logic [COLOR_W-1:0] r, g, b;
        logic [PAT_W-1:0]   pat;
        logic [NUM_CH-1:0]  lit;
        op   = t_opcode'(user[1:0]);
        base = user[2] ? LED_CH : 0;
        r    = data[7:0];
        g    = data[15:8];
        b    = data[23:16];
        pat  = data[31:25];
        status.start = 1'b0;
        case (op)
            OP_TICK: begin
                // pins follow the active duties; duties reload when the phase wraps to zero
                if (!full_mode) begin
                    lit = '0;
                    for (int i = 0; i < NUM_CH; i++)
                        if (pwm_phase < active_duty[i]) lit[i] = 1'b1;
                    pin_state = lit;
                    pwm_phase = pwm_phase - 1'b1;
                    if (pwm_phase == '0) begin
                        active_duty = pending_duty;
                        if (period_ticks != TICK_MAX) period_ticks = period_ticks + 1'b1;
                        status.start = 1'b1;
                    end
                end
            end
            OP_COLOUR: begin
                full_mode = 1'b0;
                load_pending(base, r, g, b);
                // near white is swapped once for a varying colour
                if (!data[24] && pending_duty[base] > WHITE_LIMIT &&
                    pending_duty[base + 1] > WHITE_LIMIT &&
                    pending_duty[base + 2] > WHITE_LIMIT) begin
                    variation_count = variation_count + 1'b1;
                    load_pending(base, COLOR_W'(variation_count[DUTY_BITS-1:0]),
                                 COLOR_W'(period_ticks[DUTY_BITS-1:0]), '0);
                end
            end
            OP_FULL: begin
                full_mode = 1'b1;
                pin_state = {pat[6:4], pat[2:0]};
            end
            default: ;
        endcase
        status.pins  = invert_mode ? ~pin_state : pin_state;
        status.ticks = period_ticks;
    endtask

    task automatic check_field(input string field, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            o_fail_count++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
        end
    endtask

    // watch config writes and both channels
    always @(posedge i_clk) begin
        t_led_status want, got;
        if (!i_rst_n) begin
            scale_mode      = 1'b0;
            invert_mode     = 1'b0;
            full_mode       = 1'b0;
            pwm_phase       = '0;
            period_ticks    = '0;
            variation_count = '0;
            pin_state       = '0;
            for (int i = 0; i < NUM_CH; i++) begin
                pending_duty[i] = '0;
                active_duty[i]  = '0;
            end
            status_due.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SCALING: scale_mode  = i_cfg_data[0];
                    CFG_INVERT:  invert_mode = i_cfg_data[0];
                    default: ;
                endcase
            end
            // compare before taking new words so a same-edge result cannot match them
            if (i_m_tvalid && i_m_tready) begin
                got.pins  = i_m_tdata[NUM_CH-1:0];
                got.ticks = i_m_tdata[OUT_TICK_MSB:OUT_TICK_LSB];
                got.start = i_m_tdata[OUT_START_BIT];
                if (status_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: output word expected none, got %h", $time, i_m_tdata);
                end else begin
                    want = status_due.pop_front();
                    check_field("led_pins", want.pins, got.pins);
                    check_field("tick_count", want.ticks, got.ticks);
                    check_field("period_start", want.start, got.start);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_word(i_s_tdata, i_s_tuser, want);
                status_due.push_back(want);
            end
            o_outstanding <= status_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// top of the dual rgb led pwm controller testbench: clock, reset, stimulus and verdict
// depends on drlp_pkg, dual_rgb_led_pwm_controller and led_pwm_checker
module testbench;
    import drlp_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    // red[7:0], green[15:8], blue[23:16], allow_white[24], full_pattern[31:25]
    logic [IN_DATA_W-1:0]  i_s_tdata;
    // opcode[1:0], led_select[2]
    logic [IN_USER_W-1:0]  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // led_pins[5:0], tick_count[21:6], period_start[22], zero[23]
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int   fail_count;
    int   outstanding;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic scaling_on;
    logic hold_toggle;
    logic hold_seen;
    int   hold_left;

    dual_rgb_led_pwm_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    led_pwm_checker status_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(8_000_000);
        $display("testbench: done, errors");
        $finish;
    end

    // result side: random stalls, plus a long hold-off each time one is requested
    initial begin
        i_m_tready = 1'b0;
        hold_seen  = 1'b0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_toggle) begin
                hold_seen = hold_toggle;
                hold_left = 500;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // offer one word; valid stays high afterwards unless the next word idles first
    task automatic send_word(input t_opcode op, input logic led, input logic [COLOR_W-1:0] r,
                             input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b,
                             input logic sw, input logic [PAT_W-1:0] pat);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pat, sw, b, g, r};
        i_s_tuser  <= {led, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_random_word();
        int unsigned        pick;
        t_opcode            op;
        logic [COLOR_W-1:0] r, g, b;
        logic               sw;
        pick = $urandom_range(0, 99);
        r    = COLOR_W'($urandom);
        g    = COLOR_W'($urandom);
        b    = COLOR_W'($urandom);
        sw   = 1'($urandom);
        if (pick < 64)
            op = OP_TICK;
        else if (pick < 86)
            op = OP_COLOUR;
        else if (pick < 93)
            op = OP_FULL;
        else
            op = OP_NOP;
        // a third of the colour words land near white so the substitute path runs
        if (op == OP_COLOUR && $urandom_range(0, 2) == 0) begin
            sw = ($urandom_range(0, 3) == 0);
            if (scaling_on) begin
                r = COLOR_W'($urandom_range(215, 255));
                g = COLOR_W'($urandom_range(215, 255));
                b = COLOR_W'($urandom_range(215, 255));
            end else begin
                r = {2'($urandom), 6'($urandom_range(51, 63))};
                g = {2'($urandom), 6'($urandom_range(51, 63))};
                b = {2'($urandom), 6'($urandom_range(51, 63))};
            end
        end
        send_word(op, 1'($urandom), r, g, b, sw, PAT_W'($urandom));
    endtask

    // stop offering and wait for every owed output word
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_config(input logic scale_on, input logic invert_on);
        wait_idle();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SCALING;
        i_cfg_data <= scale_on;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_INVERT;
        i_cfg_data <= invert_on;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        scaling_on = scale_on;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        scaling_on     = 1'b0;
        hold_toggle    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain conversion: wrapped duties, white threshold edges, full patterns
        write_config(1'b0, 1'b0);
        send_word(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 7'h00);
        send_word(OP_COLOUR, 1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 7'h00);
        send_word(OP_COLOUR, 1'b1, 8'd0,   8'd0,   8'd0,   1'b0, 7'h00);
        send_word(OP_COLOUR, 1'b0, 8'd50,  8'd63,  8'd63,  1'b0, 7'h00);
        send_word(OP_COLOUR, 1'b1, 8'd51,  8'd51,  8'd51,  1'b0, 7'h00);
        send_word(OP_COLOUR, 1'b0, 8'd127, 8'd191, 8'd255, 1'b0, 7'h00);
        send_word(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 7'h00);
        send_word(OP_FULL,   1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 7'h7F);
        send_word(OP_TICK,   1'b1, 8'd255, 8'd255, 8'd255, 1'b1, 7'h7F);
        send_word(OP_NOP,    1'b1, 8'd255, 8'd255, 8'd255, 1'b1, 7'h7F);
        send_word(OP_FULL,   1'b1, 8'd0,   8'd0,   8'd0,   1'b0, 7'h08);
        send_word(OP_COLOUR, 1'b0, 8'd1,   8'd2,   8'd3,   1'b1, 7'h00);
        send_word(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 7'h00);
        send_word(OP_NOP,    1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 7'h00);

        // scaled conversion: zero scale, brightest at full, scaled near white
        write_config(1'b1, 1'b0);
        send_word(OP_COLOUR, 1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 7'h00);
        send_word(OP_COLOUR, 1'b1, 8'd255, 8'd128, 8'd1,   1'b1, 7'h00);
        send_word(OP_COLOUR, 1'b0, 8'd250, 8'd240, 8'd245, 1'b0, 7'h00);
        send_word(OP_COLOUR, 1'b1, 8'd0,   8'd0,   8'd1,   1'b1, 7'h00);
        send_word(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 7'h00);
        repeat (400) send_random_word();

        // inverted pins, sender idling
        write_config(1'b0, 1'b1);
        send_idle_pct = 60;
        repeat (400) send_random_word();

        // scaled and inverted, receiver stalling, then a long hold-off under full load
        write_config(1'b1, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 60;
        repeat (400) send_random_word();
        hold_toggle = ~hold_toggle;
        repeat (40) send_random_word();

        // light idling on both sides with a full drain in the middle
        write_config(1'b0, 1'b0);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        repeat (220) send_random_word();
        wait_idle();
        repeat (220) send_random_word();

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/drlp_pkg.sv
rtl/drlp_front.sv
rtl/drlp_div.sv
rtl/drlp_back.sv
rtl/dual_rgb_led_pwm_controller.sv
rtl/drlp_checker.sv
tb/led_pwm_checker.sv
tb/testbench.sv
